// File: rtl/core/r10u_pkg.sv
// Shared types and constants for the RAW10 unpack and window crop block.
// Used by r10u_step and raw10_unpack_window_crop; no dependencies.
`default_nettype none

package r10u_pkg;

  // Field widths.
  localparam int unsigned ColW   = 13;
  localparam int unsigned RowW   = 12;
  localparam int unsigned GrpW   = 10;
  localparam int unsigned PixW   = 10;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 13;

  // The phase at which the low-bits byte arrives, and the last raw row index.
  localparam logic [PhaseW-1:0] LowBytePhase = 3'd4;
  localparam logic [RowW-1:0]   LastRawRow   = 12'd4095;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] RegLineBytes   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegStartGroup  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegStartRow    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegWidthGroups = 3'd3;
  localparam logic [CfgIdxW-1:0] RegHeightRows  = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [ColW-1:0] LineBytesRst   = 13'd4128;
  localparam logic [GrpW-1:0] StartGroupRst  = 10'd0;
  localparam logic [RowW-1:0] StartRowRst    = 12'd0;
  localparam logic [GrpW-1:0] WidthGroupsRst = 10'd820;
  localparam logic [RowW-1:0] HeightRowsRst  = 12'd2464;

  typedef struct packed {
    logic [ColW-1:0] line_bytes;
    logic [GrpW-1:0] start_group;
    logic [RowW-1:0] start_row;
    logic [GrpW-1:0] width_groups;
    logic [RowW-1:0] height_rows;
  } cfg_t;

  // Position and assembly state carried from one byte to the next.
  typedef struct packed {
    logic [ColW-1:0]   byte_column;
    logic [RowW-1:0]   raw_row;
    logic [PhaseW-1:0] group_phase;
    logic [GrpW-1:0]   group_count;
    logic [31:0]       high_bytes;
    logic              frame_done;
  } pos_t;

  typedef struct packed {
    logic [PixW-1:0] pixel0;
    logic [PixW-1:0] pixel1;
    logic [PixW-1:0] pixel2;
    logic [PixW-1:0] pixel3;
    logic [RowW-1:0] pixel_column;
    logic [RowW-1:0] pixel_row;
    logic            frame_last;
  } group_t;

endpackage

`default_nettype wire

// File: rtl/core/r10u_step.sv
// Per-byte step logic: window test, group assembly and position advance.
// Purely combinational; depends on r10u_pkg for the state and result types.
`default_nettype none

module r10u_step (
  input  wire r10u_pkg::cfg_t   cfg,
  input  wire r10u_pkg::pos_t   pos,
  input  wire logic [7:0]       raw_byte,
  input  wire logic             frame_start,
  output r10u_pkg::pos_t        pos_nxt,
  output r10u_pkg::group_t      grp,
  output logic                  grp_valid
);

  r10u_pkg::pos_t                 cur;
  logic [r10u_pkg::ColW-1:0]      first_col;
  logic [r10u_pkg::ColW-1:0]      win_bytes;
  logic [r10u_pkg::ColW-1:0]      col_off;
  logic [r10u_pkg::RowW-1:0]      row_off;
  logic [r10u_pkg::ColW:0]        col_inc;
  logic                           row_in;
  logic                           col_in;
  logic                           is_last;

  // A frame start clears the position before the byte is used.
  assign cur = frame_start ? '0 : pos;

  // Window bounds in bytes: groups times five as shift and add.
  assign first_col = {1'b0, cfg.start_group, 2'b00} + {3'b000, cfg.start_group};
  assign win_bytes = {1'b0, cfg.width_groups, 2'b00} + {3'b000, cfg.width_groups};
  assign col_off   = cur.byte_column - first_col;
  assign row_off   = cur.raw_row - cfg.start_row;
  assign row_in    = (cur.raw_row >= cfg.start_row) && (row_off < cfg.height_rows);
  assign col_in    = (cur.byte_column >= first_col) && (col_off < win_bytes);
  assign col_inc   = {1'b0, cur.byte_column} + 14'd1;

  assign is_last = (row_off == cfg.height_rows - 12'd1) &&
                   (cur.group_count == cfg.width_groups - 10'd1);

  // Result fields; only meaningful when grp_valid is set.
  always_comb begin
    grp.pixel0       = {cur.high_bytes[31:24], raw_byte[7:6]};
    grp.pixel1       = {cur.high_bytes[23:16], raw_byte[5:4]};
    grp.pixel2       = {cur.high_bytes[15:8],  raw_byte[3:2]};
    grp.pixel3       = {cur.high_bytes[7:0],   raw_byte[1:0]};
    grp.pixel_column = {cur.group_count, 2'b00};
    grp.pixel_row    = row_off;
    grp.frame_last   = is_last;
  end

  // Next position and assembly state.
  always_comb begin
    pos_nxt   = cur;
    grp_valid = 1'b0;
    if (!cur.frame_done) begin
      if (row_in && col_in) begin
        if (cur.group_phase < r10u_pkg::LowBytePhase) begin
          pos_nxt.high_bytes  = {cur.high_bytes[23:0], raw_byte};
          pos_nxt.group_phase = cur.group_phase + 3'd1;
        end else begin
          grp_valid           = 1'b1;
          pos_nxt.group_phase = '0;
          pos_nxt.group_count = cur.group_count + 10'd1;
          if (is_last) begin
            pos_nxt.frame_done = 1'b1;
          end
        end
      end
      // Line end: wrap the column and drop any partial group.
      if (col_inc >= {1'b0, cfg.line_bytes}) begin
        pos_nxt.byte_column = '0;
        pos_nxt.group_phase = '0;
        pos_nxt.group_count = '0;
        if (cur.raw_row == r10u_pkg::LastRawRow) begin
          pos_nxt.frame_done = 1'b1;
        end else begin
          pos_nxt.raw_row = cur.raw_row + 12'd1;
        end
      end else begin
        pos_nxt.byte_column = col_inc[r10u_pkg::ColW-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/raw10_unpack_window_crop.sv
// RAW10 byte stream unpacker with window crop: top level with input and result registers.
// Depends on r10u_pkg and r10u_step.
// A group shows on out_tvalid once its low-bits byte has passed the input register and then the result register.
// Throughput: one byte per cycle unless out_tready stalls the result register; the position state loops once per byte.
// Reset (rst_n low, synchronous): both stages empty, position cleared,
// configuration registers back to their default values.
`default_nettype none

module raw10_unpack_window_crop (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration write port
  input  wire logic        cfg_wr_en,
  input  wire logic [r10u_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [r10u_pkg::CfgDataW-1:0] cfg_data,
  // Input byte stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] raw_byte
  input  wire logic        in_tuser,   // [0] frame_start
  // Unpacked group stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // pixel0, pixel1, pixel2, pixel3, pixel_column, pixel_row
  output logic             out_tlast   // frame_last
);

  r10u_pkg::cfg_t    cfg_r;
  r10u_pkg::pos_t    pos_r;
  r10u_pkg::pos_t    pos_nxt;
  r10u_pkg::group_t  grp_nxt;
  r10u_pkg::group_t  grp_r;
  logic              grp_valid_nxt;
  logic              in_valid_r;
  logic [7:0]        byte_r;
  logic              start_r;
  logic              out_valid_r;
  logic              advance;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.line_bytes   <= r10u_pkg::LineBytesRst;
      cfg_r.start_group  <= r10u_pkg::StartGroupRst;
      cfg_r.start_row    <= r10u_pkg::StartRowRst;
      cfg_r.width_groups <= r10u_pkg::WidthGroupsRst;
      cfg_r.height_rows  <= r10u_pkg::HeightRowsRst;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        r10u_pkg::RegLineBytes:   cfg_r.line_bytes   <= cfg_data;
        r10u_pkg::RegStartGroup:  cfg_r.start_group  <= cfg_data[9:0];
        r10u_pkg::RegStartRow:    cfg_r.start_row    <= cfg_data[11:0];
        r10u_pkg::RegWidthGroups: cfg_r.width_groups <= cfg_data[9:0];
        r10u_pkg::RegHeightRows:  cfg_r.height_rows  <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // The held byte moves on whenever the result register has room this cycle.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r  <= in_tdata;
      start_r <= in_tuser;
    end
  end

  r10u_step u_step (
    .cfg         (cfg_r),
    .pos         (pos_r),
    .raw_byte    (byte_r),
    .frame_start (start_r),
    .pos_nxt     (pos_nxt),
    .grp         (grp_nxt),
    .grp_valid   (grp_valid_nxt)
  );

  // Position state advances once per processed byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (advance) begin
      pos_r <= pos_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= grp_valid_nxt;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && grp_valid_nxt) begin
      grp_r <= grp_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {grp_r.pixel_row, grp_r.pixel_column, grp_r.pixel3,
                       grp_r.pixel2, grp_r.pixel1, grp_r.pixel0};
  assign out_tlast  = grp_r.frame_last;

  // The low-bits byte is the fifth; the phase never runs past it.
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r.group_phase <= r10u_pkg::LowBytePhase)
    else $error("group phase out of range");

  // Emitting the final group of the window closes the frame.
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && grp_valid_nxt && grp_nxt.frame_last) |=> pos_r.frame_done)
    else $error("frame not closed after final group");

  // The final group sits in the bottom-right corner of the window.
  a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |->
      (grp_r.pixel_row == cfg_r.height_rows - 12'd1) &&
      (grp_r.pixel_column == {cfg_r.width_groups - 10'd1, 2'b00}))
    else $error("final group not at window corner");

  // A closed frame produces nothing until the next frame start.
  a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r.frame_done && !start_r) |-> !grp_valid_nxt)
    else $error("group emitted after frame end");

endmodule

`default_nettype wire
